>>> design/ugeb_pkg.sv
package ugeb_pkg;

	localparam int COORD_W = 16;
	localparam int GW_W    = 11;
	localparam int CNT_W   = 11;
	localparam int ENT_W   = 16;
	localparam int CFG_W   = 16;
	localparam int CIX_W   = 2;
	localparam int DIVN_W  = 17;
	localparam int SPAN_W  = 17;
	localparam int PROD_W  = COORD_W + GW_W;
	localparam int ADDR_W  = 29;

	localparam logic [CIX_W-1:0] REG_CELL_SIZE  = 2'd0;
	localparam logic [CIX_W-1:0] REG_GRID_WIDTH = 2'd1;
	localparam logic [CIX_W-1:0] REG_GRID_CELLS = 2'd2;

	localparam logic [CFG_W-1:0] RST_CELL_SIZE  = 16'd32;
	localparam logic [GW_W-1:0]  RST_GRID_WIDTH = 11'd32;
	localparam logic [GW_W-1:0]  RST_GRID_CELLS = 11'd1024;

	localparam logic [1:0] DIV_START_X = 2'd0;
	localparam logic [1:0] DIV_END_X   = 2'd1;
	localparam logic [1:0] DIV_START_Y = 2'd2;
	localparam logic [1:0] DIV_END_Y   = 2'd3;

	typedef struct packed {
		logic               kind;
		logic [ENT_W-1:0]   entity;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [COORD_W-1:0] dim_w;
		logic [COORD_W-1:0] dim_h;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] cells_covered;
		logic [CNT_W-1:0] cells_changed;
		logic             overflow;
	} result_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DIV_GO, S_DIV_WAIT, S_MUL, S_SETUP, S_ROW, S_CELL,
		S_FILL, S_SCAN, S_CMP, S_MISS, S_HIT, S_SHIFT_RD, S_SHIFT_WR, S_NEXT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic div_go;
		logic mul;
		logic setup;
		logic row_init;
		logic row_next;
		logic cell_go;
		logic fill_take;
		logic slot_rd;
		logic slot_next;
		logic append;
		logic set_ovf;
		logic shift_rd;
		logic shift_wr;
		logic remove;
		logic x_next;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic div_last;
		logic row_end;
		logic cell_end;
		logic last_row;
		logic scan_end;
		logic match;
		logic unreg;
		logic full;
		logic shift_more;
		logic out_busy;
	} status_t;

endpackage

>>> design/ugeb_ifs.sv
interface ugeb_item_if;
	import ugeb_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ugeb_result_if;
	import ugeb_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ugeb_cfg_if;
	import ugeb_pkg::*;
	logic             valid;
	logic             ready;
	logic [CIX_W-1:0] index;
	logic [CFG_W-1:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> design/ugeb_div.sv
module ugeb_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [ugeb_pkg::DIVN_W-1:0]  num,
	input  logic [ugeb_pkg::COORD_W-1:0] den,
	output logic                        done,
	output logic [ugeb_pkg::DIVN_W-1:0]  quo
);
	import ugeb_pkg::*;

	localparam int CW = $clog2(DIVN_W + 1);

	logic [COORD_W-1:0] rem_q;
	logic [DIVN_W-1:0]  quo_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [COORD_W:0]   trial;
	logic               fits;

	assign trial = {rem_q, quo_q[DIVN_W-1]};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q  <= CW'(DIVN_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? COORD_W'(trial - {1'b0, den}) : trial[COORD_W-1:0];
			quo_q <= {quo_q[DIVN_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> design/ugeb_dp.sv
module ugeb_dp #(
	parameter int MAX_CELLS      = 1024,
	parameter int SLOTS_PER_CELL = 8,
	parameter int ENTITY_BITS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	ugeb_cfg_if.sink           cfg,
	input  ugeb_pkg::item_t    item_data,
	ugeb_result_if.source      result,
	input  ugeb_pkg::cmd_t     cmd,
	output ugeb_pkg::status_t  status
);
	import ugeb_pkg::*;

	localparam int CIDX_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int SCNT_W  = $clog2(SLOTS_PER_CELL + 1);
	localparam int EDEPTH  = MAX_CELLS * SLOTS_PER_CELL;
	localparam int EADDR_W = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;

	logic [CFG_W-1:0]   cell_size_q;
	logic [GW_W-1:0]    grid_width_q;
	logic [GW_W-1:0]    grid_cells_q;

	item_t              item_q;
	logic [ENTITY_BITS-1:0] ent_q;
	logic [31:0]        ent_ext;

	logic [1:0]         div_sel_q;
	logic [DIVN_W-1:0]  div_num;
	logic [COORD_W-1:0] div_den;
	logic               div_done;
	logic [DIVN_W-1:0]  div_quo;
	logic [COORD_W-1:0] sx_q;
	logic [COORD_W-1:0] sy_q;
	logic [DIVN_W-1:0]  ex_q;
	logic [DIVN_W-1:0]  ey_q;
	logic [PROD_W-1:0]  prod_q;

	logic [SPAN_W-1:0]  w_q;
	logic [SPAN_W-1:0]  rows_q;
	logic [SPAN_W-1:0]  r_q;
	logic [SPAN_W-1:0]  x_q;
	logic [ADDR_W-1:0]  base_q;
	logic [ADDR_W-1:0]  idx;
	logic [ADDR_W-1:0]  limit;
	logic [CIDX_W-1:0]  idx_q;
	logic [CIDX_W-1:0]  clr_q;

	logic [SCNT_W-1:0]  n_q;
	logic [SCNT_W-1:0]  i_q;
	logic [SCNT_W-1:0]  i_inc;

	logic [CNT_W-1:0]   covered_q;
	logic [CNT_W-1:0]   changed_q;
	logic               ovf_q;
	result_t            res_q;
	logic               res_valid_q;

	logic [SCNT_W-1:0]  fill_mem [MAX_CELLS];
	logic [SCNT_W-1:0]  fill_rd_q;
	logic               fill_we;
	logic [CIDX_W-1:0]  fill_waddr;
	logic [SCNT_W-1:0]  fill_wdata;

	logic [ENTITY_BITS-1:0] ent_mem [EDEPTH];
	logic [ENTITY_BITS-1:0] ent_rd_q;
	logic               ent_we;
	logic [EADDR_W-1:0] ent_waddr;
	logic [ENTITY_BITS-1:0] ent_wdata;
	logic [EADDR_W-1:0] ent_raddr;
	logic [EADDR_W-1:0] row_addr;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q  <= RST_CELL_SIZE;
			grid_width_q <= RST_GRID_WIDTH;
			grid_cells_q <= RST_GRID_CELLS;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_CELL_SIZE:  cell_size_q  <= cfg.wdata;
				REG_GRID_WIDTH: grid_width_q <= cfg.wdata[GW_W-1:0];
				REG_GRID_CELLS: grid_cells_q <= cfg.wdata[GW_W-1:0];
				default: ;
			endcase
		end
	end

	assign ent_ext = 32'(item_data.entity);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item_data;
			ent_q  <= ENTITY_BITS'(ent_ext);
		end
	end

	always_comb begin
		case (div_sel_q)
			DIV_START_X: div_num = {1'b0, item_q.pos_x};
			DIV_END_X:   div_num = {1'b0, item_q.pos_x} + {1'b0, item_q.dim_w};
			DIV_START_Y: div_num = {1'b0, item_q.pos_y};
			default:     div_num = {1'b0, item_q.pos_y} + {1'b0, item_q.dim_h};
		endcase
	end

	assign div_den = (cell_size_q == '0) ? COORD_W'(1) : cell_size_q;

	ugeb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_sel_q <= DIV_START_X;
		end else if (cmd.load) begin
			div_sel_q <= DIV_START_X;
		end else if (div_done) begin
			div_sel_q <= div_sel_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (div_sel_q)
				DIV_START_X: sx_q <= div_quo[COORD_W-1:0];
				DIV_END_X:   ex_q <= div_quo;
				DIV_START_Y: sy_q <= div_quo[COORD_W-1:0];
				default:     ey_q <= div_quo;
			endcase
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(sy_q * grid_width_q);
		end
	end

	assign limit = (grid_cells_q < ADDR_W'(MAX_CELLS)) ? ADDR_W'(grid_cells_q)
		: ADDR_W'(MAX_CELLS);
	assign idx   = base_q + ADDR_W'(x_q);

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			base_q <= ADDR_W'(sx_q) + ADDR_W'(prod_q);
			w_q    <= SPAN_W'(ex_q - {1'b0, sx_q});
			rows_q <= (grid_width_q == '0) ? '0 : SPAN_W'(ey_q - {1'b0, sy_q});
			r_q    <= '0;
		end else if (cmd.row_next) begin
			base_q <= base_q + ADDR_W'(grid_width_q);
			r_q    <= r_q + 1'b1;
		end
		if (cmd.row_init) begin
			if ((r_q != '0) && (SPAN_W'(grid_width_q) <= w_q)) begin
				x_q <= w_q + 1'b1 - SPAN_W'(grid_width_q);
			end else begin
				x_q <= '0;
			end
		end else if (cmd.x_next) begin
			x_q <= x_q + 1'b1;
		end
		if (cmd.cell_go) begin
			idx_q <= idx[CIDX_W-1:0];
		end
	end

	assign i_inc = i_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			i_q       <= '0;
			covered_q <= '0;
			changed_q <= '0;
			ovf_q     <= 1'b0;
			clr_q     <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.load) begin
				covered_q <= '0;
				changed_q <= '0;
				ovf_q     <= 1'b0;
			end
			if (cmd.cell_go) begin
				covered_q <= covered_q + 1'b1;
			end
			if (cmd.append || cmd.remove) begin
				changed_q <= changed_q + 1'b1;
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.fill_take) begin
				n_q <= fill_rd_q;
				i_q <= '0;
			end else if (cmd.slot_next || cmd.shift_wr) begin
				i_q <= i_inc;
			end
		end
	end

	always_comb begin
		fill_we    = cmd.clr_step || cmd.append || cmd.remove;
		fill_waddr = cmd.clr_step ? clr_q : idx_q;
		if (cmd.clr_step) begin
			fill_wdata = '0;
		end else if (cmd.append) begin
			fill_wdata = n_q + 1'b1;
		end else begin
			fill_wdata = n_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_waddr] <= fill_wdata;
		end
		if (cmd.cell_go) begin
			fill_rd_q <= fill_mem[idx[CIDX_W-1:0]];
		end
	end

	assign row_addr  = EADDR_W'(idx_q * SLOTS_PER_CELL);
	assign ent_raddr = row_addr + EADDR_W'(cmd.shift_rd ? i_inc : i_q);

	always_comb begin
		ent_we    = cmd.append || cmd.shift_wr;
		ent_waddr = row_addr + EADDR_W'(cmd.append ? n_q : i_q);
		ent_wdata = cmd.append ? ent_q : ent_rd_q;
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
		if (cmd.slot_rd || cmd.shift_rd) begin
			ent_rd_q <= ent_mem[ent_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.cells_covered <= covered_q;
			res_q.cells_changed <= changed_q;
			res_q.overflow      <= ovf_q;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	always_comb begin
		status.clr_last   = clr_q == CIDX_W'(MAX_CELLS - 1);
		status.div_done   = div_done;
		status.div_last   = div_sel_q == DIV_END_Y;
		status.row_end    = base_q >= limit;
		status.cell_end   = (x_q > w_q) || (idx >= limit);
		status.last_row   = r_q == rows_q;
		status.scan_end   = i_q >= n_q;
		status.match      = ent_rd_q == ent_q;
		status.unreg      = item_q.kind;
		status.full       = n_q >= SCNT_W'(SLOTS_PER_CELL);
		status.shift_more = i_inc < n_q;
		status.out_busy   = res_valid_q && !result.ready;
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= SCNT_W'(SLOTS_PER_CELL))
		else $error("Cell fill exceeds the slot count.");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		i_q <= n_q)
		else $error("Slot index ran past the cell fill.");

	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		changed_q <= covered_q)
		else $error("More cells changed than covered.");

endmodule

>>> design/ugeb_ctrl.sv
module ugeb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  ugeb_pkg::status_t status,
	output ugeb_pkg::cmd_t    cmd
);
	import ugeb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:    if (status.clr_last) state_d = S_IDLE;
			S_IDLE:     if (item_valid) state_d = S_DIV_GO;
			S_DIV_GO:   state_d = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (status.div_done) begin
					state_d = status.div_last ? S_MUL : S_DIV_GO;
				end
			end
			S_MUL:      state_d = S_SETUP;
			S_SETUP:    state_d = S_ROW;
			S_ROW:      state_d = status.row_end ? S_DONE : S_CELL;
			S_CELL: begin
				if (status.cell_end) begin
					state_d = status.last_row ? S_DONE : S_ROW;
				end else begin
					state_d = S_FILL;
				end
			end
			S_FILL:     state_d = S_SCAN;
			S_SCAN:     state_d = status.scan_end ? S_MISS : S_CMP;
			S_CMP:      state_d = status.match ? S_HIT : S_SCAN;
			S_MISS:     state_d = S_NEXT;
			S_HIT:      state_d = status.unreg ? S_SHIFT_RD : S_NEXT;
			S_SHIFT_RD: state_d = status.shift_more ? S_SHIFT_WR : S_NEXT;
			S_SHIFT_WR: state_d = S_SHIFT_RD;
			S_NEXT:     state_d = S_CELL;
			S_DONE:     if (!status.out_busy) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			S_CLEAR:  cmd.clr_step = 1'b1;
			S_IDLE: begin
				item_ready = 1'b1;
				cmd.load   = item_valid;
			end
			S_DIV_GO: cmd.div_go = 1'b1;
			S_MUL:    cmd.mul = 1'b1;
			S_SETUP:  cmd.setup = 1'b1;
			S_ROW:    cmd.row_init = !status.row_end;
			S_CELL: begin
				if (status.cell_end) begin
					cmd.row_next = !status.last_row;
				end else begin
					cmd.cell_go = 1'b1;
				end
			end
			S_FILL:   cmd.fill_take = 1'b1;
			S_SCAN:   cmd.slot_rd = !status.scan_end;
			S_CMP:    cmd.slot_next = !status.match;
			S_MISS: begin
				if (!status.unreg) begin
					cmd.set_ovf = status.full;
					cmd.append  = !status.full;
				end
			end
			S_SHIFT_RD: begin
				cmd.shift_rd = status.shift_more;
				cmd.remove   = !status.shift_more;
			end
			S_SHIFT_WR: cmd.shift_wr = 1'b1;
			S_NEXT:     cmd.x_next = 1'b1;
			S_DONE:     cmd.finish = !status.out_busy;
			default: ;
		endcase
	end

endmodule

>>> design/uniform_grid_entity_binning.sv
// Uniform grid binning: each transaction registers or unregisters one entity over the
// cells covered by its box and returns one result with covered and changed cell counts
// and an overflow flag. After reset the block clears the cell fill memory before it
// takes its first item. One item at a time is processed: four divisions run one after
// another on a single bit-serial divider, then a multiply and a setup step, then each
// covered cell reads its fill count, scans its slots one at a time and, on removal,
// shifts the later entries down one slot.
// The result sits in an output register, so a new item is taken while it waits.
module uniform_grid_entity_binning #(
	parameter int MAX_CELLS      = 1024,
	parameter int SLOTS_PER_CELL = 8,
	parameter int ENTITY_BITS    = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	ugeb_cfg_if.sink      cfg,
	ugeb_item_if.sink     item,
	ugeb_result_if.source result
);
	import ugeb_pkg::*;

	cmd_t    cmd;
	status_t status;
	logic    ctrl_ready;

	ugeb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (ctrl_ready),
		.status     (status),
		.cmd        (cmd)
	);

	ugeb_dp #(
		.MAX_CELLS      (MAX_CELLS),
		.SLOTS_PER_CELL (SLOTS_PER_CELL),
		.ENTITY_BITS    (ENTITY_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item_data (item.data),
		.result    (result),
		.cmd       (cmd),
		.status    (status)
	);

	assign item.ready = ctrl_ready;

endmodule
